@@ rtl/pswfl_pkg.sv @@
// Package for the per-source fixed-window limiter.
// Holds reset values, register indexes, the table entry type and the FSM type.
// No dependencies.
`timescale 1ns / 1ps

package pswfl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS   = 2'd1;

  localparam logic [15:0] WINDOW_RESET       = 16'd60;
  localparam logic [15:0] MAX_ATTEMPTS_RESET = 16'd100;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] count;
    logic [31:0] win_begin;
  } slot_t;

  typedef struct packed {
    logic  en;
    slot_t data;
  } tbl_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

@@ rtl/pswfl_in_if.sv @@
// Input channel of the limiter: source address and current time.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface pswfl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] now_seconds;

  modport source (output valid, output src_addr, output now_seconds, input ready);
  modport sink   (input valid, input src_addr, input now_seconds, output ready);
endinterface

@@ rtl/pswfl_out_if.sv @@
// Result channel of the limiter: one over_limit flag per transaction.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps

interface pswfl_out_if;
  logic valid;
  logic ready;
  logic over_limit;

  modport source (output valid, output over_limit, input ready);
  modport sink   (input valid, input over_limit, output ready);
endinterface

@@ rtl/pswfl_table.sv @@
// Source table storage: one write port, one read port, registered read data.
// Depends on pswfl_pkg for the entry and write-port types.
`timescale 1ns / 1ps

module pswfl_table #(
  parameter int DEPTH = pswfl_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  pswfl_pkg::tbl_wr_t  wr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [IDX_W-1:0]    rd_addr,
  output pswfl_pkg::slot_t    rd_data
);
  import pswfl_pkg::*;

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/per_source_fixed_window_limiter_top.sv @@
// Per-source fixed-window rate limiter. Each input transaction (address, time)
// gives one over_limit result. Address zero skips the table and needs no lookup.
// Any other address walks the filled part of the table one entry per cycle
// through the single read port of the table memory. Slots fill in order and are
// never evicted, so a fill count marks the valid entries and no clearing pass
// is needed after reset. Results wait in an output register; a new transaction
// is taken while an earlier result is still pending.
// Depends on pswfl_pkg, pswfl_in_if, pswfl_out_if and pswfl_table.
`timescale 1ns / 1ps

module per_source_fixed_window_limiter_top #(
  parameter int TABLE_ENTRIES = pswfl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pswfl_in_if.sink                          in_chan,
  pswfl_out_if.source                       out_chan,
  input  logic                              cfg_we,
  input  logic [pswfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pswfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pswfl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  logic [15:0] window_r, max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
      max_r    <= MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SECONDS: window_r <= cfg_data;
        REG_MAX_ATTEMPTS:   max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             out_lim_r, out_lim_nxt;
  logic [31:0]      ip_r, ip_nxt;
  logic [31:0]      now_r, now_nxt;

  tbl_wr_t          wr;
  logic [IDX_W-1:0] wr_addr;
  slot_t            rd_data;

  pswfl_table #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // hit arithmetic on the entry read in the previous cycle
  logic        hit;
  logic [31:0] elapsed;
  logic        expired;
  logic [31:0] cnt_inc;

  assign hit     = cmp_vld_r && (rd_data.address == ip_r);
  assign elapsed = now_r - rd_data.win_begin;
  assign expired = elapsed >= {16'd0, window_r};
  assign cnt_inc = (rd_data.count == COUNT_MAX) ? rd_data.count : rd_data.count + 32'd1;

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_vld_r;
  assign out_chan.over_limit = out_lim_r;

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    res_nxt     = res_r;
    ip_nxt      = ip_r;
    now_nxt     = now_r;
    out_vld_nxt = out_vld_r;
    out_lim_nxt = out_lim_r;
    wr.en       = 1'b0;
    wr.data     = '{address: ip_r, count: 32'd1, win_begin: now_r};
    wr_addr     = cmp_idx_r;

    if (out_vld_r && out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          ip_nxt     = in_chan.src_addr;
          now_nxt    = in_chan.now_seconds;
          rd_idx_nxt = '0;
          res_nxt    = 1'b0;
          state_nxt  = (in_chan.src_addr == 32'd0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          wr.en = 1'b1;
          if (expired) begin
            res_nxt = 1'b0;
          end else begin
            wr.data = '{address: ip_r, count: cnt_inc, win_begin: rd_data.win_begin};
            res_nxt = cnt_inc > {16'd0, max_r};
          end
          state_nxt = ST_DONE;
        end else if (rd_idx_r < used_r) begin
          // keep one read in flight ahead of the compare
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end else begin
          // miss: allocate the next free slot if any
          res_nxt = 1'b0;
          if (used_r < FULL) begin
            wr.en    = 1'b1;
            wr_addr  = used_r[IDX_W-1:0];
            used_nxt = used_r + CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt = 1'b1;
          out_lim_nxt = res_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    res_r     <= res_nxt;
    ip_r      <= ip_nxt;
    now_r     <= now_nxt;
    out_lim_r <= out_lim_nxt;
  end

endmodule
